>>> hw/rtl/ocl_pkg.sv
// Shared types and constants for the ordered identifier list.
// Used by ocl_cell and ordered_id_list_insert_remove; depends on nothing.
package ocl_pkg;

    // Default sizing handed to the top-level parameters
    localparam int DEPTH_DEF   = 16;
    localparam int ID_BITS_DEF = 16;

    // Fixed widths of the result fields
    localparam int ENTRY_ID_W  = 16;
    localparam int NEW_INDEX_W = 4;
    localparam int POSITION_W  = 8;

    // Request kinds carried on the slave tuser
    localparam logic OP_REMOVE = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    // Result status carried on the master tuser
    typedef enum logic [1:0] {
        ST_RENUM   = 2'd0,
        ST_TAIL    = 2'd1,
        ST_IGNORED = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    // Per-cycle command broadcast to every cell of the ring
    typedef struct packed {
        logic rotate;  // every cell takes its upper neighbour
        logic insert;  // open a gap at the position and drop the id in
        logic remove;  // close the gap at the position
    } t_cell_ctl;

endpackage

>>> hw/rtl/ordered_id_list_insert_remove.sv
// Top level of the ordered identifier list: sequencer, ring of ocl_cell
// slots and the result register. Depends on ocl_pkg and ocl_cell.
//
//  Channel   Direction  Handshake             Payload
//  s_axis    in         i_s_axis_tvalid/o_..  tdata: item_id, position; tuser: operation
//  m_axis    out        o_m_axis_tvalid/i_..  tdata: entry_id, new_index; tuser: status;
//                                             tlast: last
//
//  A request makes a full revolution of the ring to look up the identifier,
//  passes the update state that inserts or removes, and then makes a
//  second revolution that streams the renumbered entries out of cell 0.
//  Requests giving a single result skip the second revolution; a removal at the
//  tail of the list passes the update state before its single result.
//  Reset clears the entry count and the sequencer; slot contents stay as is.
//  A stalled master side freezes the second revolution until the result
//  register drains; a new request is taken while the last result still waits.
module ordered_id_list_insert_remove
    import ocl_pkg::*;
#(
    parameter int DEPTH   = DEPTH_DEF,
    parameter int ID_BITS = ID_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // slave side
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // [ID_BITS-1:0] item_id, [ID_BITS+7:ID_BITS] position, rest zero
    input  logic [((ID_BITS+POSITION_W+7)/8)*8-1:0] i_s_axis_tdata,
    // [0] operation
    input  logic                                  i_s_axis_tuser,
    // master side
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // [15:0] entry_id, [19:16] new_index, [23:20] zero
    output logic [23:0]                           o_m_axis_tdata,
    // [1:0] status
    output logic [1:0]                            o_m_axis_tuser,
    output logic                                  o_m_axis_tlast
);

    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int POS_CMP_W = (CNT_W > POSITION_W) ? CNT_W : POSITION_W;
    localparam logic [IDX_W-1:0] LAST_K  = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SEARCH = 5'b00010,
        S_APPLY  = 5'b00100,
        S_EMIT   = 5'b01000,
        S_SINGLE = 5'b10000
    } t_state;

    t_state                  r_state, n_state;
    logic                    r_op, n_op;
    logic [ID_BITS-1:0]      r_id, n_id;
    logic [POSITION_W-1:0]   r_pos, n_pos;
    logic [IDX_W-1:0]        r_k, n_k;
    logic                    r_found, n_found;
    logic [IDX_W-1:0]        r_at, n_at;
    logic [IDX_W-1:0]        r_from, n_from;
    logic                    r_tail, n_tail;
    t_status                 r_status, n_status;
    logic [CNT_W-1:0]        r_count, n_count;

    logic                    r_out_valid;
    logic [ENTRY_ID_W-1:0]   r_out_id;
    logic [NEW_INDEX_W-1:0]  r_out_index;
    t_status                 r_out_status;
    logic                    r_out_last;

    t_cell_ctl               w_ctl;
    logic [ID_BITS-1:0]      w_slot [DEPTH];
    logic [ID_BITS-1:0]      w_head;
    logic                    w_out_free;
    logic                    w_last_k;
    logic                    w_hit;
    logic                    w_found_any;
    logic [IDX_W-1:0]        w_at_any;
    logic [IDX_W-1:0]        w_clamp;
    logic                    w_in_range;
    logic                    w_load;
    logic [ID_BITS-1:0]      w_load_id;
    logic [IDX_W-1:0]        w_load_idx;
    t_status                 w_load_status;
    logic                    w_load_last;

    // Ring of slots, each cell fed by both neighbours
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        ocl_cell #(
            .IDX     (i),
            .IDX_W   (IDX_W),
            .ID_BITS (ID_BITS)
        ) u_cell (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_from (r_from),
            .i_id   (r_id),
            .i_prev (w_slot[(i + DEPTH - 1) % DEPTH]),
            .i_next (w_slot[(i + 1) % DEPTH]),
            .o_slot (w_slot[i])
        );
    end

    assign w_head      = w_slot[0];
    assign w_out_free  = !r_out_valid || i_m_axis_tready;
    assign w_last_k    = (r_k == LAST_K);
    assign w_hit       = (CNT_W'(r_k) < r_count) && (w_head == r_id);
    assign w_found_any = r_found || w_hit;
    assign w_at_any    = r_found ? r_at : r_k;
    assign w_clamp     = (POS_CMP_W'(r_pos) > POS_CMP_W'(r_count)) ?
                         IDX_W'(r_count) : IDX_W'(r_pos);
    assign w_in_range  = (CNT_W'(r_k) >= CNT_W'(r_from)) && (CNT_W'(r_k) < r_count);

    // Sequence lookup, update and result streaming
    always_comb begin
        n_state       = r_state;
        n_op          = r_op;
        n_id          = r_id;
        n_pos         = r_pos;
        n_k           = r_k;
        n_found       = r_found;
        n_at          = r_at;
        n_from        = r_from;
        n_tail        = r_tail;
        n_status      = r_status;
        n_count       = r_count;
        w_ctl         = '0;
        w_load        = 1'b0;
        w_load_id     = '0;
        w_load_idx    = '0;
        w_load_status = r_status;
        w_load_last   = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_op    = i_s_axis_tuser;
                    n_id    = i_s_axis_tdata[ID_BITS-1:0];
                    n_pos   = i_s_axis_tdata[ID_BITS+POSITION_W-1:ID_BITS];
                    n_k     = '0;
                    n_found = 1'b0;
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                w_ctl.rotate = 1'b1;
                n_k          = w_last_k ? '0 : r_k + 1'b1;
                if (w_hit && !r_found) begin
                    n_found = 1'b1;
                    n_at    = r_k;
                end
                if (w_last_k) begin
                    if (r_op == OP_REMOVE) begin
                        if (!w_found_any) begin
                            n_status = ST_IGNORED;
                            n_state  = S_SINGLE;
                        end else begin
                            n_from   = w_at_any;
                            n_tail   = (CNT_W'(w_at_any) + 1'b1 == r_count);
                            n_status = ST_TAIL;
                            n_state  = S_APPLY;
                        end
                    end else begin
                        if (w_found_any) begin
                            n_status = ST_IGNORED;
                            n_state  = S_SINGLE;
                        end else if (r_count == FULL_CNT) begin
                            n_status = ST_FULL;
                            n_state  = S_SINGLE;
                        end else begin
                            n_from  = w_clamp;
                            n_tail  = 1'b0;
                            n_state = S_APPLY;
                        end
                    end
                end
            end
            S_APPLY: begin
                w_ctl.insert = (r_op == OP_INSERT);
                w_ctl.remove = (r_op == OP_REMOVE);
                n_count      = (r_op == OP_INSERT) ? r_count + 1'b1 : r_count - 1'b1;
                n_k          = '0;
                n_state      = r_tail ? S_SINGLE : S_EMIT;
            end
            S_EMIT: begin
                if (w_in_range && w_out_free) begin
                    w_load        = 1'b1;
                    w_load_id     = w_head;
                    w_load_idx    = r_k;
                    w_load_status = ST_RENUM;
                    w_load_last   = (CNT_W'(r_k) + 1'b1 == r_count);
                end
                // hold the ring while a result waits for room
                if (!w_in_range || w_out_free) begin
                    w_ctl.rotate = 1'b1;
                    n_k          = w_last_k ? '0 : r_k + 1'b1;
                    if (w_last_k) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SINGLE: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_found <= 1'b0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_found <= n_found;
            r_count <= n_count;
        end
    end

    // Request payload registers
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_id     <= n_id;
        r_pos    <= n_pos;
        r_at     <= n_at;
        r_from   <= n_from;
        r_tail   <= n_tail;
        r_status <= n_status;
    end

    // Result register: load a new transaction or drop the one taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_id     <= ENTRY_ID_W'(w_load_id);
            r_out_index  <= NEW_INDEX_W'(w_load_idx);
            r_out_status <= w_load_status;
            r_out_last   <= w_load_last;
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0000, r_out_index, r_out_id};
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tlast  = r_out_last;

    // The list never outgrows the ring
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count beyond ring depth");

    // Every update changes the entry count
    a_apply_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_APPLY |=> r_count != $past(r_count))
        else $error("update left entry count unchanged");

    // The ring is back in place whenever the block is idle
    a_ring_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> r_k == '0)
        else $error("ring left rotated at idle");

    // Lookup ends after one full revolution
    a_search_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH && w_last_k) |=> r_state != S_SEARCH)
        else $error("lookup ran past one revolution");

    // Any result other than a renumbered entry closes its request
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_load_status != ST_RENUM) |=> r_out_last)
        else $error("status result not marked last");

endmodule

>>> hw/rtl/ocl_cell.sv
// One slot of the identifier ring: holds a single identifier and updates it
// from its neighbours or from the request. Depends on ocl_pkg for the command struct.
module ocl_cell
    import ocl_pkg::*;
#(
    parameter int IDX     = 0,
    parameter int IDX_W   = 4,
    parameter int ID_BITS = ID_BITS_DEF
) (
    input  logic               i_clk,
    input  t_cell_ctl          i_ctl,
    input  logic [IDX_W-1:0]   i_from,
    input  logic [ID_BITS-1:0] i_id,
    input  logic [ID_BITS-1:0] i_prev,
    input  logic [ID_BITS-1:0] i_next,
    output logic [ID_BITS-1:0] o_slot
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [ID_BITS-1:0] r_slot;

    // Rotate, shift up behind an insert and take the new id at its position, or shift down over a removal
    always_ff @(posedge i_clk) begin
        priority if (i_ctl.rotate) begin
            r_slot <= i_next;
        end else if (i_ctl.insert) begin
            if (MY_IDX > i_from) begin
                r_slot <= i_prev;
            end else if (MY_IDX == i_from) begin
                r_slot <= i_id;
            end
        end else if (i_ctl.remove) begin
            if (MY_IDX >= i_from) begin
                r_slot <= i_next;
            end
        end else begin
            // hold the slot while the ring is idle
            r_slot <= r_slot;
        end
    end

    assign o_slot = r_slot;

endmodule
